// File: design/mat_pkg.sv
`timescale 1ns / 1ps
package mat_pkg;

	localparam int NPTS  = 1024;
	localparam int AW    = 10;
	localparam int ACC_W = 58;
	localparam int PW    = 48;
	localparam int RW    = 13;
	localparam int KMAX  = 64;
	localparam int HMAX  = 32;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_PREP = 2'd1,
		ACT_TEND = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_B  = 3'd0,
		REG_SS = 3'd1,
		REG_C  = 3'd2,
		REG_F  = 3'd3,
		REG_K  = 3'd4,
		REG_H  = 3'd5,
		REG_M3 = 3'd6,
		REG_N  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED,
		S_WREAD,
		S_WMUL,
		S_WACC,
		S_DIV,
		S_DIVEND,
		S_FREAD,
		S_FLATCH,
		S_MMUL,
		S_MACC,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		DST_PW,
		DST_PX,
		DST_PREP,
		DST_FETCH
	} dst_t;

	typedef enum logic [2:0] {
		F_W2K = 3'd0,
		F_WK  = 3'd1,
		F_G   = 3'd2,
		F_M2  = 3'd3,
		F_M1  = 3'd4,
		F_P1  = 3'd5
	} fetch_t;

	typedef enum logic [2:0] {
		M_WW   = 3'd0,
		M_YY1  = 3'd1,
		M_YY2  = 3'd2,
		M_YX1  = 3'd3,
		M_YX2  = 3'd4,
		M_SS   = 3'd5,
		M_CP   = 3'd6,
		M_DAMP = 3'd7
	} mul_t;

	typedef struct packed {
		logic signed [31:0] b;
		logic signed [31:0] ss;
		logic signed [31:0] c;
		logic signed [31:0] f;
		logic [6:0]         k;
		logic [5:0]         h;
		logic               m3;
		logic [10:0]        n;
	} cfg_t;

	typedef struct packed {
		action_t            act;
		logic [AW-1:0]      idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cmd_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} fr_stat_t;

	typedef struct packed {
		logic idle;
		logic done;
	} bk_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff});
		lo = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});
		if (v > hi)
			return 32'sh7fffffff;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [RW-1:0] fetch_off(input fetch_t fi, input logic [6:0] k);
		logic signed [RW-1:0] kk;
		kk = $signed({{(RW-7){1'b0}}, k});
		case (fi)
			F_W2K:   return -(kk <<< 1);
			F_WK:    return -kk;
			F_G:     return '0;
			F_M2:    return -$signed(RW'(2));
			F_M1:    return -$signed(RW'(1));
			F_P1:    return $signed(RW'(1));
			default: return '0;
		endcase
	endfunction

endpackage

// File: design/multiscale_advection_tendency_core.sv
`timescale 1ns / 1ps
// Multiscale advection tendency core.
// Input words (action, index, large_value, small_value) arrive on item_valid /
// item_stall; results (out_index, tendency) leave on result_valid / result_stall.
// A load writes one x/y sample pair; prepare rebuilds every window average;
// a tendency returns dz for one grid point. Out-of-range indices and the
// unused action are dropped at the front without a result.
// A two-word queue sits between the front and the sequencer, so words are
// taken while the sequencer works or while a result waits in the output
// register. One item is executed at a time, one multiplier and one bit-serial
// divider shared by all steps.
// Load: written straight from idle. Tendency: window products, a division by
// 2K, point fetches and final products, with more fetches and products in
// model III than in model II, plus wrap steps for tiny rings. Prepare: a
// window sum and a division by 2K for each of the n points.
// Reset restores the register defaults and empties the queue; the sample and
// average stores are undefined until written. A stalled result holds and the
// sequencer waits before loading the next one.
module multiscale_advection_tendency_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         action,
	input  logic [9:0]         index,
	input  logic signed [31:0] large_value,
	input  logic signed [31:0] small_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [9:0]         out_index,
	output logic signed [31:0] tendency
);

	logic signed [31:0] b_q, ss_q, c_q, f_q;
	logic [6:0]         k_q;
	logic [5:0]         h_q;
	logic               m3_q;
	logic [10:0]        n_q;

	mat_pkg::cfg_t     cfg;
	mat_pkg::cmd_t     cmd;
	mat_pkg::fr_stat_t fr_stat;
	mat_pkg::bk_stat_t bk_stat;
	logic              cmd_avail, cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q  <= 32'sd655360;
			ss_q <= 32'sd6553600;
			c_q  <= 32'sd163840;
			f_q  <= 32'sd983040;
			k_q  <= 7'd32;
			h_q  <= 6'd16;
			m3_q <= 1'b0;
			n_q  <= 11'd1024;
		end else if (cfg_write) begin
			unique case (mat_pkg::reg_idx_t'(cfg_index))
				mat_pkg::REG_B:  b_q  <= cfg_data;
				mat_pkg::REG_SS: ss_q <= cfg_data;
				mat_pkg::REG_C:  c_q  <= cfg_data;
				mat_pkg::REG_F:  f_q  <= cfg_data;
				mat_pkg::REG_K:  k_q  <= cfg_data[6:0];
				mat_pkg::REG_H:  h_q  <= cfg_data[5:0];
				mat_pkg::REG_M3: m3_q <= cfg_data[0];
				mat_pkg::REG_N:  n_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.b  = b_q;
		cfg.ss = ss_q;
		cfg.c  = c_q;
		cfg.f  = f_q;
		cfg.m3 = m3_q;
		if (k_q == 7'd0)
			cfg.k = 7'd1;
		else if (k_q > 7'(mat_pkg::KMAX))
			cfg.k = 7'(mat_pkg::KMAX);
		else
			cfg.k = k_q;
		cfg.h = (h_q > 6'(mat_pkg::HMAX)) ? 6'(mat_pkg::HMAX) : h_q;
		if (n_q == 11'd0)
			cfg.n = 11'd1;
		else if (n_q > 11'(mat_pkg::NPTS))
			cfg.n = 11'(mat_pkg::NPTS);
		else
			cfg.n = n_q;
	end

	mat_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.index       (index),
		.large_value (large_value),
		.small_value (small_value),
		.n           (cfg.n),
		.cmd_pop     (cmd_pop),
		.cmd_avail   (cmd_avail),
		.cmd         (cmd),
		.stat        (fr_stat)
	);

	mat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_avail    (cmd_avail),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_index    (out_index),
		.tendency     (tendency),
		.stat         (bk_stat)
	);

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (bk_stat.idle && cmd_avail))
		else $error("word taken from queue while sequencer busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(bk_stat.done))
		else $error("result raised outside completion");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_stat.count == 2'd2) |=> (fr_stat.count != 2'd0 && fr_stat.count != 2'd3))
		else $error("queue count out of range");

endmodule

// File: design/mat_front.sv
`timescale 1ns / 1ps
module mat_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          action,
	input  logic [9:0]          index,
	input  logic signed [31:0]  large_value,
	input  logic signed [31:0]  small_value,
	input  logic [10:0]         n,
	input  logic                cmd_pop,
	output logic                cmd_avail,
	output mat_pkg::cmd_t       cmd,
	output mat_pkg::fr_stat_t   stat
);

	mat_pkg::cmd_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          keep;
	logic          push;
	mat_pkg::action_t act;

	assign act = mat_pkg::action_t'(action);

	always_comb begin
		unique case (act)
			mat_pkg::ACT_LOAD, mat_pkg::ACT_TEND: keep = {1'b0, index} < n;
			mat_pkg::ACT_PREP:                    keep = 1'b1;
			default:                              keep = 1'b0;
		endcase
	end

	assign item_stall = cnt_q == 2'd2;
	assign push       = item_valid && !item_stall && keep;
	assign cmd_avail  = cnt_q != 2'd0;
	assign cmd        = ent_q[rp_q];
	assign stat.count = cnt_q;
	assign stat.full  = item_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{act: act, idx: index, x: large_value, y: small_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (cmd_pop)
				rp_q <= !rp_q;
			if (push && !cmd_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && cmd_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: design/mat_back.sv
`timescale 1ns / 1ps
module mat_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mat_pkg::cfg_t             cfg,
	input  logic                      cmd_avail,
	input  mat_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [9:0]                out_index,
	output logic signed [31:0]        tendency,
	output mat_pkg::bk_stat_t         stat
);

	localparam int AW    = mat_pkg::AW;
	localparam int RW    = mat_pkg::RW;
	localparam int ACC_W = mat_pkg::ACC_W;
	localparam int PW    = mat_pkg::PW;

	mat_pkg::state_t state_q, state_d;
	mat_pkg::dst_t   dst_q;
	mat_pkg::fetch_t fi_q;
	mat_pkg::mul_t   mi_q;

	logic [AW-1:0]           g_q, pw_q, px_q;
	logic [6:0]              j_q;
	logic signed [RW-1:0]    red_q;
	logic                    tend_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        dq_q;
	logic [7:0]              rem_q;
	logic                    neg_q;
	logic [5:0]              dcnt_q;
	logic signed [63:0]      prod_q;
	logic signed [PW-1:0]    t1_q;
	logic signed [31:0]      w2k_q, wk_q, y0_q, ym2_q, ym1_q, yp1_q, xm1_q, xp1_q;
	logic signed [31:0]      advy_q, advxy_q;

	logic signed [31:0] large_mem [mat_pkg::NPTS];
	logic signed [31:0] small_mem [mat_pkg::NPTS];
	logic signed [31:0] avg_mem   [mat_pkg::NPTS];
	logic signed [31:0] xd_q, yd_q, wd_q;

	logic                    ld_we, avg_we, res_load, out_free;
	logic [AW-1:0]           l_addr, a_addr, red_addr, pw_inc, px_inc;
	logic signed [RW-1:0]    gs, cs, ks, hs, ns;
	logic                    red_neg, red_hi, red_ok;
	logic [6:0]              h2;
	logic                    j_last, j_first, dbl;
	logic signed [PW-1:0]    p48;
	logic signed [ACC_W-1:0] term_src, term, acc_sum, acc_abs, quot, diff;
	logic [7:0]              d8;
	logic [8:0]              r2, r2s;
	logic                    ge;
	logic                    g_last, f_last, m_last;
	logic signed [31:0]      opa, opb;

	assign gs  = $signed({{(RW-AW){1'b0}}, g_q});
	assign cs  = $signed({{(RW-AW){1'b0}}, cmd.idx});
	assign ks  = $signed({{(RW-7){1'b0}}, cfg.k});
	assign hs  = $signed({{(RW-6){1'b0}}, cfg.h});
	assign ns  = $signed({{(RW-11){1'b0}}, cfg.n});

	assign red_neg  = red_q[RW-1];
	assign red_hi   = !red_neg && (red_q >= ns);
	assign red_ok   = !red_neg && !red_hi;
	assign red_addr = red_q[AW-1:0];

	assign pw_inc = (({1'b0, pw_q} + 11'd1) == cfg.n) ? '0 : pw_q + 1'b1;
	assign px_inc = (({1'b0, px_q} + 11'd1) == cfg.n) ? '0 : px_q + 1'b1;

	assign l_addr = (state_q == mat_pkg::S_FREAD) ? red_addr : px_q;
	assign a_addr = (state_q == mat_pkg::S_FREAD) ? red_addr : pw_q;

	assign h2      = {cfg.h, 1'b0};
	assign j_last  = j_q == h2;
	assign j_first = j_q == 7'd0;
	assign dbl     = (cfg.h == 6'd0) || !(j_first || j_last);

	assign p48      = prod_q[63:16];
	assign term_src = tend_q ? ACC_W'(p48) : ACC_W'(xd_q);
	assign term     = dbl ? (term_src <<< 1) : term_src;
	assign acc_sum  = acc_q + term;
	assign acc_abs  = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;

	assign d8   = {cfg.k, 1'b0};
	assign r2   = {rem_q, dq_q[ACC_W-1]};
	assign r2s  = r2 - {1'b0, d8};
	assign ge   = r2 >= {1'b0, d8};
	assign quot = neg_q ? -$signed(dq_q) : $signed(dq_q);
	assign diff = ACC_W'(t1_q) - ACC_W'(p48);

	assign g_last = {1'b0, g_q} == (cfg.n - 11'd1);
	assign f_last = fi_q == (cfg.m3 ? mat_pkg::F_P1 : mat_pkg::F_G);
	assign m_last = mi_q == (cfg.m3 ? mat_pkg::M_DAMP : mat_pkg::M_WW);

	assign out_free = !result_valid || !result_stall;

	always_comb begin
		unique case (mi_q)
			mat_pkg::M_WW:   begin opa = w2k_q;  opb = wk_q;    end
			mat_pkg::M_YY1:  begin opa = ym1_q;  opb = yp1_q;   end
			mat_pkg::M_YY2:  begin opa = ym2_q;  opb = ym1_q;   end
			mat_pkg::M_YX1:  begin opa = ym1_q;  opb = xp1_q;   end
			mat_pkg::M_YX2:  begin opa = ym2_q;  opb = xm1_q;   end
			mat_pkg::M_SS:   begin opa = cfg.ss; opb = advy_q;  end
			mat_pkg::M_CP:   begin opa = cfg.c;  opb = advxy_q; end
			mat_pkg::M_DAMP: begin opa = cfg.b;  opb = y0_q;    end
			default:         begin opa = '0;     opb = '0;      end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mat_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		ld_we    = 1'b0;
		avg_we   = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			mat_pkg::S_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					if (cmd.act == mat_pkg::ACT_LOAD)
						ld_we = 1'b1;
					else
						state_d = mat_pkg::S_RED;
				end
			end
			mat_pkg::S_RED: begin
				if (red_ok) begin
					unique case (dst_q)
						mat_pkg::DST_PW:              state_d = mat_pkg::S_RED;
						mat_pkg::DST_PX, mat_pkg::DST_PREP: state_d = mat_pkg::S_WREAD;
						default:                      state_d = mat_pkg::S_FREAD;
					endcase
				end
			end
			mat_pkg::S_WREAD: state_d = tend_q ? mat_pkg::S_WMUL : mat_pkg::S_WACC;
			mat_pkg::S_WMUL:  state_d = mat_pkg::S_WACC;
			mat_pkg::S_WACC:  state_d = j_last ? mat_pkg::S_DIV : mat_pkg::S_WREAD;
			mat_pkg::S_DIV: begin
				if (dcnt_q == 6'(ACC_W - 1))
					state_d = mat_pkg::S_DIVEND;
			end
			mat_pkg::S_DIVEND: begin
				if (tend_q) begin
					state_d = mat_pkg::S_RED;
				end else begin
					avg_we  = 1'b1;
					state_d = g_last ? mat_pkg::S_IDLE : mat_pkg::S_RED;
				end
			end
			mat_pkg::S_FREAD:  state_d = mat_pkg::S_FLATCH;
			mat_pkg::S_FLATCH: state_d = f_last ? mat_pkg::S_MMUL : mat_pkg::S_RED;
			mat_pkg::S_MMUL:   state_d = mat_pkg::S_MACC;
			mat_pkg::S_MACC:   state_d = m_last ? mat_pkg::S_DONE : mat_pkg::S_MMUL;
			mat_pkg::S_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = mat_pkg::S_IDLE;
				end
			end
			default: state_d = mat_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			large_mem[cmd.idx] <= cmd.x;
			small_mem[cmd.idx] <= cmd.y;
		end
		if (avg_we)
			avg_mem[g_q] <= mat_pkg::sat32(quot);
		xd_q <= large_mem[l_addr];
		yd_q <= small_mem[l_addr];
		wd_q <= avg_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mat_pkg::S_IDLE: begin
				if (cmd_avail && cmd.act != mat_pkg::ACT_LOAD) begin
					tend_q <= cmd.act == mat_pkg::ACT_TEND;
					acc_q  <= '0;
					j_q    <= '0;
					if (cmd.act == mat_pkg::ACT_TEND) begin
						g_q   <= cmd.idx;
						red_q <= cs - ks - hs;
						dst_q <= mat_pkg::DST_PW;
					end else begin
						g_q   <= '0;
						red_q <= -hs;
						dst_q <= mat_pkg::DST_PREP;
					end
				end
			end
			mat_pkg::S_RED: begin
				if (red_neg) begin
					red_q <= red_q + ns;
				end else if (red_hi) begin
					red_q <= red_q - ns;
				end else begin
					case (dst_q)
						mat_pkg::DST_PW: begin
							pw_q  <= red_addr;
							red_q <= gs + ks - hs;
							dst_q <= mat_pkg::DST_PX;
						end
						mat_pkg::DST_PX, mat_pkg::DST_PREP: px_q <= red_addr;
						default: ;
					endcase
				end
			end
			mat_pkg::S_WMUL: prod_q <= wd_q * xd_q;
			mat_pkg::S_WACC: begin
				acc_q <= acc_sum;
				pw_q  <= pw_inc;
				px_q  <= px_inc;
				j_q   <= j_q + 7'd1;
				if (j_last) begin
					dq_q   <= acc_abs;
					neg_q  <= acc_sum[ACC_W-1];
					rem_q  <= '0;
					dcnt_q <= '0;
				end
			end
			mat_pkg::S_DIV: begin
				dq_q   <= {dq_q[ACC_W-2:0], ge};
				rem_q  <= ge ? r2s[7:0] : r2[7:0];
				dcnt_q <= dcnt_q + 6'd1;
			end
			mat_pkg::S_DIVEND: begin
				if (tend_q) begin
					acc_q <= quot;
					fi_q  <= mat_pkg::F_W2K;
					red_q <= gs + mat_pkg::fetch_off(mat_pkg::F_W2K, cfg.k);
					dst_q <= mat_pkg::DST_FETCH;
				end else if (!g_last) begin
					g_q   <= g_q + 1'b1;
					red_q <= gs + $signed(RW'(1)) - hs;
					dst_q <= mat_pkg::DST_PREP;
					acc_q <= '0;
					j_q   <= '0;
				end
			end
			mat_pkg::S_FLATCH: begin
				case (fi_q)
					mat_pkg::F_W2K: w2k_q <= wd_q;
					mat_pkg::F_WK:  wk_q  <= wd_q;
					mat_pkg::F_G: begin
						acc_q <= acc_q - ACC_W'(xd_q) + ACC_W'(cfg.f);
						y0_q  <= yd_q;
					end
					mat_pkg::F_M2:  ym2_q <= yd_q;
					mat_pkg::F_M1: begin
						ym1_q <= yd_q;
						xm1_q <= xd_q;
					end
					default: begin
						yp1_q <= yd_q;
						xp1_q <= xd_q;
					end
				endcase
				if (f_last) begin
					mi_q <= mat_pkg::M_WW;
				end else begin
					fi_q  <= mat_pkg::fetch_t'(fi_q + 3'd1);
					red_q <= gs + mat_pkg::fetch_off(mat_pkg::fetch_t'(fi_q + 3'd1), cfg.k);
				end
			end
			mat_pkg::S_MMUL: prod_q <= opa * opb;
			mat_pkg::S_MACC: begin
				case (mi_q)
					mat_pkg::M_WW, mat_pkg::M_DAMP: acc_q <= acc_q - ACC_W'(p48);
					mat_pkg::M_YY1, mat_pkg::M_YX1: t1_q <= p48;
					mat_pkg::M_YY2: advy_q  <= mat_pkg::sat32(diff);
					mat_pkg::M_YX2: advxy_q <= mat_pkg::sat32(diff);
					default:        acc_q <= acc_q + ACC_W'(p48);
				endcase
				if (!m_last)
					mi_q <= mat_pkg::mul_t'(mi_q + 3'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_index <= g_q;
			tendency  <= mat_pkg::sat32(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (res_load)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	assign stat.idle = state_q == mat_pkg::S_IDLE;
	assign stat.done = state_q == mat_pkg::S_DONE;

endmodule
